@@ src/gfps_pkg.sv @@
// Package with widths, status codes and the slot entry type of the GNSS frame pair sync.
package gfps_pkg;

	localparam int TIME_W = 30;
	localparam int ROLL_W = 16;
	localparam int PAY_W  = 64;
	localparam int WIN_W  = 10;
	localparam int SLOT_W = 3;

	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(10);

	typedef enum logic [1:0] {
		ST_PAIRED  = 2'd0,
		ST_STORED  = 2'd1,
		ST_NO_TIME = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef struct packed {
		logic              holds_main;
		logic [TIME_W-1:0] time_ms;
		logic [ROLL_W-1:0] roll;
		logic [PAY_W-1:0]  payload;
	} slot_entry_t;

endpackage

@@ src/gnss_frame_pair_sync.sv @@
// Top level of the GNSS frame pair sync: sequencer that scans the slot table one slot at a time.
// A request with a valid time scans from slot 0 and ends at the first matching slot, else at the
// last slot; one with no valid time is rejected unscanned. Each slot passes a read and a compare
// state through one shared difference and compare unit, and a held result stalls the sequencer.
// A new request is taken only after the last result is issued; in_ready is high only while idle.
// Reset (arst_n low): all slots free, window back to 10 ms, no result pending; no clearing pass.
module gnss_frame_pair_sync #(
	parameter int SLOTS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [gfps_pkg::WIN_W-1:0]            cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  main_time_valid,
	input  logic [gfps_pkg::TIME_W-1:0]           main_time,
	input  logic                                  sub_time_valid,
	input  logic [gfps_pkg::TIME_W-1:0]           sub_time,
	input  logic signed [gfps_pkg::ROLL_W-1:0]    roll,
	input  logic [gfps_pkg::PAY_W-1:0]            payload,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [1:0]                            status,
	output logic [gfps_pkg::SLOT_W-1:0]           slot,
	output logic [gfps_pkg::PAY_W-1:0]            out_payload,
	output logic [gfps_pkg::TIME_W-1:0]           out_main_time,
	output logic [gfps_pkg::TIME_W-1:0]           out_sub_time,
	output logic signed [gfps_pkg::ROLL_W-1:0]    out_roll
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_REJ
	} state_t;

	state_t                              state_q;
	logic [IDX_W-1:0]                    idx_q;
	logic [SLOTS-1:0]                    busy_q;
	logic                                free_found_q;
	logic [IDX_W-1:0]                    free_idx_q;
	logic [gfps_pkg::WIN_W-1:0]          win_q;
	logic                                is_main_q;
	logic [gfps_pkg::TIME_W-1:0]         key_q;
	logic [gfps_pkg::ROLL_W-1:0]         roll_q;
	logic [gfps_pkg::PAY_W-1:0]          pay_q;
	logic                                out_valid_q;
	gfps_pkg::status_t                   status_q;
	logic [gfps_pkg::SLOT_W-1:0]         slot_q;
	logic [gfps_pkg::PAY_W-1:0]          out_pay_q;
	logic [gfps_pkg::TIME_W-1:0]         out_mt_q;
	logic [gfps_pkg::TIME_W-1:0]         out_st_q;
	logic [gfps_pkg::ROLL_W-1:0]         out_roll_q;

	gfps_pkg::slot_entry_t               rd_entry;
	gfps_pkg::slot_entry_t               wr_entry;
	logic                                mem_we;
	logic [IDX_W-1:0]                    wr_addr;
	logic                                out_free;
	logic                                emit;
	logic [gfps_pkg::TIME_W:0]           diff_ab;
	logic [gfps_pkg::TIME_W:0]           diff_ba;
	logic [gfps_pkg::TIME_W-1:0]         abs_diff;
	logic                                hit;
	logic                                last;
	logic                                cur_busy;
	logic                                store_ok;
	logic [IDX_W+gfps_pkg::SLOT_W-1:0]   idx_ext;
	logic [IDX_W+gfps_pkg::SLOT_W-1:0]   wr_ext;

	assign out_free = !out_valid_q || out_ready;
	assign cur_busy = busy_q[idx_q];
	assign last     = (idx_q == LAST_IDX);

	assign diff_ab  = {1'b0, rd_entry.time_ms} - {1'b0, key_q};
	assign diff_ba  = {1'b0, key_q} - {1'b0, rd_entry.time_ms};
	assign abs_diff = diff_ab[gfps_pkg::TIME_W] ? diff_ba[gfps_pkg::TIME_W-1:0]
	                                            : diff_ab[gfps_pkg::TIME_W-1:0];
	assign hit      = cur_busy && (rd_entry.holds_main != is_main_q) &&
	                  (abs_diff <= gfps_pkg::TIME_W'(win_q));

	assign store_ok = free_found_q || !cur_busy;
	assign wr_addr  = free_found_q ? free_idx_q : idx_q;
	assign mem_we   = (state_q == S_CMP) && !hit && last && out_free && store_ok;
	assign emit     = out_free && (((state_q == S_CMP) && (hit || last)) || (state_q == S_REJ));

	assign wr_entry.holds_main = is_main_q;
	assign wr_entry.time_ms    = key_q;
	assign wr_entry.roll       = roll_q;
	assign wr_entry.payload    = pay_q;

	assign idx_ext = {{gfps_pkg::SLOT_W{1'b0}}, idx_q};
	assign wr_ext  = {{gfps_pkg::SLOT_W{1'b0}}, wr_addr};

	gfps_slot_mem #(
		.DEPTH (SLOTS),
		.AW    (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_addr),
		.wdata (wr_entry),
		.raddr (idx_q),
		.rdata (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			busy_q       <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			win_q        <= gfps_pkg::WIN_RESET;
			is_main_q    <= 1'b0;
			key_q        <= '0;
			roll_q       <= '0;
			pay_q        <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= gfps_pkg::ST_PAIRED;
			slot_q       <= '0;
			out_pay_q    <= '0;
			out_mt_q     <= '0;
			out_st_q     <= '0;
			out_roll_q   <= '0;
		end else begin
			if (cfg_we) begin
				win_q <= cfg_wdata;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						is_main_q    <= main_time_valid;
						key_q        <= main_time_valid ? main_time : sub_time;
						roll_q       <= roll;
						pay_q        <= payload;
						idx_q        <= '0;
						free_found_q <= 1'b0;
						state_q      <= (main_time_valid || sub_time_valid) ? S_READ : S_REJ;
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (hit) begin
						if (out_free) begin
							status_q      <= gfps_pkg::ST_PAIRED;
							slot_q        <= idx_ext[gfps_pkg::SLOT_W-1:0];
							out_pay_q     <= is_main_q ? pay_q : rd_entry.payload;
							out_mt_q      <= rd_entry.holds_main ? rd_entry.time_ms : key_q;
							out_st_q      <= is_main_q ? rd_entry.time_ms : key_q;
							out_roll_q    <= is_main_q ? rd_entry.roll : roll_q;
							busy_q[idx_q] <= 1'b0;
							state_q       <= S_IDLE;
						end
					end else if (last) begin
						if (out_free) begin
							out_pay_q   <= '0;
							out_mt_q    <= '0;
							out_st_q    <= '0;
							out_roll_q  <= '0;
							if (store_ok) begin
								status_q        <= gfps_pkg::ST_STORED;
								slot_q          <= wr_ext[gfps_pkg::SLOT_W-1:0];
								busy_q[wr_addr] <= 1'b1;
							end else begin
								status_q <= gfps_pkg::ST_FULL;
								slot_q   <= '0;
							end
							state_q <= S_IDLE;
						end
					end else begin
						if (!cur_busy && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= idx_q;
						end
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_READ;
					end
				end
				S_REJ: begin
					if (out_free) begin
						status_q    <= gfps_pkg::ST_NO_TIME;
						slot_q      <= '0;
						out_pay_q   <= '0;
						out_mt_q    <= '0;
						out_st_q    <= '0;
						out_roll_q  <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign slot          = slot_q;
	assign out_payload   = out_pay_q;
	assign out_main_time = out_mt_q;
	assign out_sub_time  = out_st_q;
	assign out_roll      = out_roll_q;

	// A pairing frees the slot that matched.
	a_pair_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP && hit && out_free) |=> !busy_q[$past(idx_q)])
		else $error("matched slot still busy after pairing");

	// A stored packet leaves its slot busy.
	a_store_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> busy_q[$past(wr_addr)])
		else $error("stored slot not marked busy");

	// The table is reported full only when every slot is busy.
	a_full_all_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP && !hit && last && out_free && !store_ok) |-> (&busy_q))
		else $error("table full reported with a free slot");

endmodule

@@ src/gfps_slot_mem.sv @@
// Slot table storage: one write port and one registered read port.
module gfps_slot_mem #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  gfps_pkg::slot_entry_t wdata,
	input  logic [AW-1:0]       raddr,
	output gfps_pkg::slot_entry_t rdata
);

	gfps_pkg::slot_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
